// ----- rtl/jas_pkg.sv -----
// shared types, constants and fixed-point helpers of the joint admittance step unit
// no dependencies; imported by every module of the block but jas_fifo
package jas_pkg;

	// result status codes
	typedef enum logic [1:0] {
		STAT_OK          = 2'd0,
		STAT_POS_LIMIT   = 2'd1,
		STAT_SPEED_LIMIT = 2'd2,
		STAT_OVERFLOW    = 2'd3
	} jas_status_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_INV_INERTIA = 2'd0,
		REG_DAMPING     = 2'd1,
		REG_STEP_TIME   = 2'd2,
		REG_MAX_STEP    = 2'd3
	} jas_reg_t;

	// back end sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADD1,
		ST_MUL2,
		ST_ADD2,
		ST_MUL3,
		ST_ADD3,
		ST_MUL4,
		ST_ADD4,
		ST_DONE
	} jas_state_t;

	// register reset values
	localparam logic [30:0] INV_INERTIA_RST = 31'd65536;
	localparam logic [30:0] DAMPING_RST     = 31'd655360;
	localparam logic [31:0] STEP_TIME_RST   = 32'd4294967;
	localparam logic [30:0] MAX_STEP_RST    = 31'h7FFF_FFFF;

	// depth of the queues between front, back and result side
	localparam int QUEUE_DEPTH = 2;

	// saturation bounds in the wide working format
	localparam logic signed [67:0] SAT_MAX = 68'sd2147483647;
	localparam logic signed [67:0] SAT_MIN = -68'sd2147483648;

	// shared register set
	typedef struct packed {
		logic [30:0] inv_inertia;
		logic [30:0] damping;
		logic [31:0] step_time;
		logic [30:0] max_step;
	} jas_cfg_t;

	// classified sample handed from front to back
	typedef struct packed {
		logic [2:0]         joint;
		logic               valid;
		logic               restart;
		logic signed [31:0] q_des;
		logic signed [31:0] q_act;
		logic signed [31:0] ext;
		logic               ext_ov;
		logic signed [31:0] pos_lower;
		logic signed [31:0] pos_upper;
	} jas_item_t;

	// one command result
	typedef struct packed {
		logic [2:0]         joint;
		logic signed [31:0] q_cmd;
		jas_status_t        status;
	} jas_res_t;

	// saturated value and its overflow flag
	typedef struct packed {
		logic               ov;
		logic signed [31:0] val;
	} jas_sat_t;

	// clamp a wide value to the signed 32-bit range
	function automatic jas_sat_t sat32(input logic signed [67:0] x);
		jas_sat_t r;
		if (x > SAT_MAX) begin
			r.ov  = 1'b1;
			r.val = 32'sh7FFF_FFFF;
		end else if (x < SAT_MIN) begin
			r.ov  = 1'b1;
			r.val = 32'sh8000_0000;
		end else begin
			r.ov  = 1'b0;
			r.val = x[31:0];
		end
		return r;
	endfunction

	// drop 16 fraction bits, round to nearest, ties up
	function automatic logic signed [67:0] rnd16(input logic signed [65:0] p);
		logic signed [67:0] t;
		t = 68'(p) + 68'sd32768;
		return t >>> 16;
	endfunction

	// drop 32 fraction bits, round to nearest, ties up
	function automatic logic signed [67:0] rnd32(input logic signed [65:0] p);
		logic signed [67:0] t;
		t = 68'(p) + 68'sd2147483648;
		return t >>> 32;
	endfunction

endpackage

// ----- rtl/jas_fifo.sv -----
// small first-in first-out queue of register slots
// depends on nothing but its parameters; used between the block's parts
module jas_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = slot_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// payload slots
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- rtl/jas_front.sv -----
// front end: classifies an incoming joint sample and forms the external torque
// depends on jas_pkg for the item type and saturation helper
module jas_front import jas_pkg::*; #(
	parameter int NUM_JOINTS = 8
) (
	input  logic [2:0]         joint,
	input  logic               restart,
	input  logic signed [31:0] q_des,
	input  logic signed [31:0] q_act,
	input  logic signed [31:0] tau_act,
	input  logic signed [31:0] grav_torque,
	input  logic signed [31:0] bias_torque,
	input  logic signed [31:0] pos_lower,
	input  logic signed [31:0] pos_upper,
	output jas_item_t          item
);

	jas_sat_t ext_sat;

	// external torque, saturated
	always_comb begin
		ext_sat = sat32(68'(tau_act) - 68'(grav_torque) - 68'(bias_torque));
	end

	// build the queued item
	always_comb begin
		item.joint     = joint;
		item.valid     = (32'(joint) < NUM_JOINTS);
		item.restart   = restart;
		item.q_des     = q_des;
		item.q_act     = q_act;
		item.ext       = ext_sat.val;
		item.ext_ov    = ext_sat.ov;
		item.pos_lower = pos_lower;
		item.pos_upper = pos_upper;
	end

endmodule

// ----- rtl/jas_back.sv -----
// back end: per-joint admittance state and the integration sequencer
// depends on jas_pkg; one shared multiplier works through four products per item
module jas_back import jas_pkg::*; #(
	parameter int NUM_JOINTS = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  jas_cfg_t  cfg,
	input  logic      in_empty,
	input  jas_item_t in_item,
	output logic      in_pop,
	input  logic      res_full,
	output logic      res_push,
	output jas_res_t  res
);

	// only eight joints are addressable by the 3-bit index
	localparam int DEPTH = (NUM_JOINTS < 8) ? NUM_JOINTS : 8;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	jas_state_t         state_q;
	jas_state_t         state_d;
	jas_item_t          item_q;
	logic signed [31:0] vel_mem [DEPTH];
	logic signed [31:0] off_mem [DEPTH];
	logic signed [31:0] vel_q;
	logic signed [31:0] off_q;
	logic signed [31:0] net_q;
	logic signed [31:0] acc_q;
	logic               ov_q;
	logic signed [65:0] prod_q;

	logic signed [31:0] vel_in;
	logic signed [31:0] off_in;
	logic               mul_en;
	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;
	logic               mem_we;
	logic               start;

	jas_sat_t           damp_r;
	jas_sat_t           net_r;
	jas_sat_t           acc_r;
	jas_sat_t           vel_r;
	jas_sat_t           off_r;
	jas_sat_t           cmd_r;
	logic signed [32:0] diff;
	logic [32:0]        diff_abs;
	jas_status_t        stat;

	assign start = (state_q == ST_IDLE) && !in_empty;

	// state read for the head item; restart or unknown joint starts from zero
	always_comb begin
		if (in_item.valid && !in_item.restart) begin
			vel_in = vel_mem[in_item.joint[IDX_W-1:0]];
			off_in = off_mem[in_item.joint[IDX_W-1:0]];
		end else begin
			vel_in = '0;
			off_in = '0;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (!in_empty) state_d = ST_ADD1;
			ST_ADD1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_ADD2;
			ST_ADD2: state_d = ST_MUL3;
			ST_MUL3: state_d = ST_ADD3;
			ST_ADD3: state_d = ST_MUL4;
			ST_MUL4: state_d = ST_ADD4;
			ST_ADD4: state_d = ST_DONE;
			ST_DONE: if (!res_full) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs: multiplier operands, queue and state strobes
	always_comb begin
		mul_en   = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		in_pop   = 1'b0;
		mem_we   = 1'b0;
		res_push = 1'b0;
		case (state_q)
			ST_IDLE: begin
				mul_en = start;
				in_pop = start;
				mul_a  = signed'({2'b00, cfg.damping});
				mul_b  = 33'(vel_in);
			end
			ST_MUL2: begin
				mul_en = 1'b1;
				mul_a  = 33'(net_q);
				mul_b  = signed'({2'b00, cfg.inv_inertia});
			end
			ST_MUL3: begin
				mul_en = 1'b1;
				mul_a  = 33'(acc_q);
				mul_b  = signed'({1'b0, cfg.step_time});
			end
			ST_MUL4: begin
				mul_en = 1'b1;
				mul_a  = 33'(vel_q);
				mul_b  = signed'({1'b0, cfg.step_time});
			end
			ST_ADD4: mem_we = item_q.valid;
			ST_DONE: res_push = !res_full;
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	// round and saturate stages fed from the product register
	always_comb begin
		damp_r = sat32(rnd16(prod_q));
		net_r  = sat32(68'(item_q.ext) - 68'(damp_r.val));
		acc_r  = sat32(rnd16(prod_q));
		vel_r  = sat32(68'(vel_q) + rnd32(prod_q));
		off_r  = sat32(68'(off_q) + rnd32(prod_q));
		cmd_r  = sat32(68'(item_q.q_des) + 68'(off_q));
	end

	// command checks, overflow ranks first
	always_comb begin
		diff     = 33'(cmd_r.val) - 33'(item_q.q_act);
		diff_abs = diff[32] ? 33'(-diff) : 33'(diff);
		if (ov_q || cmd_r.ov) begin
			stat = STAT_OVERFLOW;
		end else if (cmd_r.val < item_q.pos_lower || cmd_r.val > item_q.pos_upper) begin
			stat = STAT_POS_LIMIT;
		end else if (diff_abs > {2'b00, cfg.max_step}) begin
			stat = STAT_SPEED_LIMIT;
		end else begin
			stat = STAT_OK;
		end
		res.joint  = item_q.joint;
		res.q_cmd  = cmd_r.val;
		res.status = stat;
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// per-joint admittance state, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				vel_mem[i] <= '0;
				off_mem[i] <= '0;
			end
		end else if (mem_we) begin
			vel_mem[item_q.joint[IDX_W-1:0]] <= vel_q;
			off_mem[item_q.joint[IDX_W-1:0]] <= off_r.val;
		end
	end

	// shared multiplier, registered product
	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= mul_a * mul_b;
		end
	end

	// working registers of the item in flight
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					item_q <= in_item;
					vel_q  <= vel_in;
					off_q  <= off_in;
					ov_q   <= in_item.ext_ov;
				end
			end
			ST_ADD1: begin
				net_q <= net_r.val;
				ov_q  <= ov_q | damp_r.ov | net_r.ov;
			end
			ST_ADD2: begin
				acc_q <= acc_r.val;
				ov_q  <= ov_q | acc_r.ov;
			end
			ST_ADD3: begin
				vel_q <= vel_r.val;
				ov_q  <= ov_q | vel_r.ov;
			end
			ST_ADD4: begin
				off_q <= off_r.val;
				ov_q  <= ov_q | off_r.ov;
			end
			default: begin
				ov_q <= ov_q;
			end
		endcase
	end

	// a restart sample begins from zero velocity and offset
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && in_item.restart) |=> (vel_q == '0 && off_q == '0))
		else $error("restart did not clear working state");

	// the item in flight holds until its result leaves
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |=> $stable(item_q))
		else $error("item changed while in flight");

	// a blocked result waits in the finish state with its command unchanged
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && res_full) |=> (state_q == ST_DONE && $stable(off_q)))
		else $error("result lost while output queue full");

	// a new item is taken only after the previous result was pushed
	assert property (@(posedge clk) disable iff (!arst_n)
		in_pop |-> ($past(state_q) == ST_DONE || $past(state_q) == ST_IDLE))
		else $error("item taken while another is in flight");

endmodule

// ----- rtl/joint_admittance_step_unit.sv -----
// top level of the joint admittance step unit: ports, shared registers and queues
// depends on jas_pkg, jas_front, jas_fifo and jas_back
//
// Each accepted joint sample yields one position command. The front end takes a
// sample whenever full is low, forms the external torque and parks the sample in a
// two-entry queue; the back end works one sample at a time, in steps set by
// four products (damping, acceleration, velocity step, offset step) that pass in turn
// through one shared 33x33 multiplier, each followed by a round-and-saturate cycle;
// the first product is issued in the cycle that fetches the sample and its joint
// state, and a finish cycle forms the command and its status.
// Results wait in a two-entry queue read by pop; a full result queue holds the back
// end in its finish cycle. Joint state (offset and velocity) is cleared at reset with
// no clearing pass. Registers may be written only while no sample is in the block.
module joint_admittance_step_unit import jas_pkg::*; #(
	parameter int NUM_JOINTS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write port
	input  logic               wr_en,
	input  logic [1:0]         wr_index,
	input  logic [31:0]        wr_data,
	// sample input
	input  logic               push,
	output logic               full,
	input  logic [2:0]         joint,
	input  logic               restart,
	input  logic signed [31:0] q_des,
	input  logic signed [31:0] q_act,
	input  logic signed [31:0] tau_act,
	input  logic signed [31:0] grav_torque,
	input  logic signed [31:0] bias_torque,
	input  logic signed [31:0] pos_lower,
	input  logic signed [31:0] pos_upper,
	// command output
	output logic               empty,
	input  logic               pop,
	output logic [2:0]         joint_out,
	output logic signed [31:0] q_cmd,
	output logic [1:0]         status
);

	localparam int ITEM_W = $bits(jas_item_t);
	localparam int RES_W  = $bits(jas_res_t);

	jas_cfg_t          cfg_q;
	jas_item_t         front_item;
	jas_item_t         back_item;
	logic [ITEM_W-1:0] back_item_raw;
	logic              item_empty;
	logic              item_pop;
	jas_res_t          back_res;
	logic              res_push;
	logic              res_full;
	logic [RES_W-1:0]  res_raw;
	jas_res_t          head_res;

	// shared configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inv_inertia <= INV_INERTIA_RST;
			cfg_q.damping     <= DAMPING_RST;
			cfg_q.step_time   <= STEP_TIME_RST;
			cfg_q.max_step    <= MAX_STEP_RST;
		end else if (wr_en) begin
			case (jas_reg_t'(wr_index))
				REG_INV_INERTIA: cfg_q.inv_inertia <= wr_data[30:0];
				REG_DAMPING:     cfg_q.damping     <= wr_data[30:0];
				REG_STEP_TIME:   cfg_q.step_time   <= wr_data;
				REG_MAX_STEP:    cfg_q.max_step    <= wr_data[30:0];
				default:         cfg_q <= cfg_q;
			endcase
		end
	end

	// classify the incoming sample
	jas_front #(
		.NUM_JOINTS (NUM_JOINTS)
	) u_front (
		.joint       (joint),
		.restart     (restart),
		.q_des       (q_des),
		.q_act       (q_act),
		.tau_act     (tau_act),
		.grav_torque (grav_torque),
		.bias_torque (bias_torque),
		.pos_lower   (pos_lower),
		.pos_upper   (pos_upper),
		.item        (front_item)
	);

	// queue between front and back
	jas_fifo #(
		.WIDTH (ITEM_W),
		.DEPTH (QUEUE_DEPTH)
	) u_item_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (front_item),
		.full      (full),
		.pop       (item_pop),
		.pop_data  (back_item_raw),
		.empty     (item_empty)
	);

	assign back_item = jas_item_t'(back_item_raw);

	// integration sequencer
	jas_back #(
		.NUM_JOINTS (NUM_JOINTS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_empty (item_empty),
		.in_item  (back_item),
		.in_pop   (item_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (back_res)
	);

	// result queue
	jas_fifo #(
		.WIDTH (RES_W),
		.DEPTH (QUEUE_DEPTH)
	) u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (back_res),
		.full      (res_full),
		.pop       (pop),
		.pop_data  (res_raw),
		.empty     (empty)
	);

	assign head_res  = jas_res_t'(res_raw);
	assign joint_out = head_res.joint;
	assign q_cmd     = head_res.q_cmd;
	assign status    = head_res.status;

endmodule

// ----- tb/sv/joint_admittance_step_unit_tb.sv -----
// self-checking testbench for joint_admittance_step_unit: queue-style push/pop handshakes
// depends on jas_pkg for status codes, register indexes and register reset values
// a local fixed-point predictor of offset/velocity per joint checks every command beat
module joint_admittance_step_unit_tb import jas_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int JOINTS = 8;
	localparam int IDLE_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 16;
	localparam int HOLD_CYCLES = 400;
	localparam int RAND_PHASES = 12;
	localparam int CHUNKS = 3;
	localparam int CHUNK_ITEMS = 52;

	localparam logic signed [31:0] W_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] W_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] ONE = 32'sh0001_0000;

	typedef struct {
		logic [2:0]         joint;
		logic               restart;
		logic signed [31:0] q_des;
		logic signed [31:0] q_act;
		logic signed [31:0] tau_act;
		logic signed [31:0] grav_torque;
		logic signed [31:0] bias_torque;
		logic signed [31:0] pos_lower;
		logic signed [31:0] pos_upper;
	} sample_t;

	typedef struct {
		logic [2:0]         joint;
		logic signed [31:0] q_cmd;
		jas_status_t        status;
	} command_t;

	// dut ports
	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               wr_en = 1'b0;
	logic [1:0]         wr_index = '0;
	logic [31:0]        wr_data = '0;
	logic               push = 1'b0;
	logic               full;
	logic [2:0]         joint = '0;
	logic               restart = 1'b0;
	logic signed [31:0] q_des = '0;
	logic signed [31:0] q_act = '0;
	logic signed [31:0] tau_act = '0;
	logic signed [31:0] grav_torque = '0;
	logic signed [31:0] bias_torque = '0;
	logic signed [31:0] pos_lower = '0;
	logic signed [31:0] pos_upper = '0;
	logic               empty;
	logic               pop = 1'b0;
	logic [2:0]         joint_out;
	logic signed [31:0] q_cmd;
	logic [1:0]         status;

	// predictor copy of registers and joint state
	longint gain_inv_inertia = longint'(INV_INERTIA_RST);
	longint gain_damping = longint'(DAMPING_RST);
	longint gain_step_time = longint'(STEP_TIME_RST);
	longint gain_max_step = longint'(MAX_STEP_RST);
	longint joint_offset[JOINTS];
	longint joint_velocity[JOINTS];

	sample_t  sample_q[$];
	command_t cmd_expect_q[$];
	int       mismatch_cnt = 0;
	int       burst_left = 0;
	int       gap_left = 0;
	int       rx_hold = 0;
	int       rx_window = 0;
	int       rx_mode = 0;
	int       idle_cycles = 0;
	logic     hold_kick = 1'b0;
	logic     hold_seen = 1'b0;

	joint_admittance_step_unit #(.NUM_JOINTS(JOINTS)) dut (.*);

	always #5 clk = ~clk;

	// saturate to the signed 32-bit range, flag any clipping
	function automatic longint clamp32(input longint x, inout bit ov);
		if (x > longint'(W_MAX)) begin
			ov = 1'b1;
			return longint'(W_MAX);
		end
		if (x < longint'(W_MIN)) begin
			ov = 1'b1;
			return longint'(W_MIN);
		end
		return x;
	endfunction

	// round to nearest, ties toward +inf, then drop n fraction bits
	function automatic longint round_shift(input longint x, input int n);
		return (x + (longint'(1) << (n - 1))) >>> n;
	endfunction

	// one semi-implicit euler admittance step; updates the joint state
	function automatic command_t admit_step(input sample_t s);
		command_t c;
		longint vel, off, ext, damp, net, acc, cmd, diff;
		bit ov;
		bit in_range;
		ov = 1'b0;
		vel = 0;
		off = 0;
		in_range = (s.joint < JOINTS);
		if (in_range && !s.restart) begin
			vel = joint_velocity[s.joint];
			off = joint_offset[s.joint];
		end
		ext  = clamp32(longint'(s.tau_act) - longint'(s.grav_torque)
			- longint'(s.bias_torque), ov);
		damp = clamp32(round_shift(gain_damping * vel, 16), ov);
		net  = clamp32(ext - damp, ov);
		acc  = clamp32(round_shift(net * gain_inv_inertia, 16), ov);
		vel  = clamp32(vel + round_shift(acc * gain_step_time, 32), ov);
		off  = clamp32(off + round_shift(vel * gain_step_time, 32), ov);
		cmd  = clamp32(longint'(s.q_des) + off, ov);
		if (in_range) begin
			joint_velocity[s.joint] = vel;
			joint_offset[s.joint] = off;
		end
		diff = cmd - longint'(s.q_act);
		if (diff < 0)
			diff = -diff;
		if (ov)
			c.status = STAT_OVERFLOW;
		else if (cmd < longint'(s.pos_lower) || cmd > longint'(s.pos_upper))
			c.status = STAT_POS_LIMIT;
		else if (diff > gain_max_step)
			c.status = STAT_SPEED_LIMIT;
		else
			c.status = STAT_OK;
		c.joint = s.joint;
		c.q_cmd = cmd[31:0];
		return c;
	endfunction

	function automatic sample_t mk(input int jt, input int rs,
		input logic signed [31:0] qd, qa, ta, tg, tof, lo, hi);
		sample_t s;
		s.joint = 3'(jt);
		s.restart = 1'(rs);
		s.q_des = qd;
		s.q_act = qa;
		s.tau_act = ta;
		s.grav_torque = tg;
		s.bias_torque = tof;
		s.pos_lower = lo;
		s.pos_upper = hi;
		return s;
	endfunction

	// random signed word in the range -2^(bits-1) to 2^(bits-1)-1
	function automatic logic signed [31:0] signed_word(input int bits);
		logic signed [31:0] w;
		w = $urandom;
		return w >>> (32 - bits);
	endfunction

	function automatic sample_t random_sample();
		sample_t s;
		logic signed [31:0] span;
		logic signed [31:0] t;
		s.joint = 3'($urandom_range(0, JOINTS - 1));
		if ($urandom_range(0, 9) == 0) begin
			// raw noise over the whole field range
			s.restart = 1'($urandom_range(0, 1));
			s.q_des = $urandom;
			s.q_act = $urandom;
			s.tau_act = $urandom;
			s.grav_torque = $urandom;
			s.bias_torque = $urandom;
			s.pos_lower = $urandom;
			s.pos_upper = $urandom;
		end else begin
			// plausible servo sample around the desired position
			s.restart = ($urandom_range(0, 24) == 0);
			s.q_des = signed_word($urandom_range(12, 28));
			s.q_act = s.q_des + signed_word($urandom_range(1, 22));
			s.tau_act = signed_word($urandom_range(4, 26));
			s.grav_torque = signed_word($urandom_range(4, 24));
			s.bias_torque = signed_word($urandom_range(1, 18));
			span = $urandom_range(1, 32'h0100_0000);
			s.pos_lower = s.q_des - span;
			s.pos_upper = s.q_des + span;
			if ($urandom_range(0, 19) == 0) begin
				t = s.pos_lower;
				s.pos_lower = s.pos_upper;
				s.pos_upper = t;
			end
		end
		return s;
	endfunction

	// register value: extremes, reset value or random; stray bit 31 on narrow registers
	function automatic logic [31:0] pick_reg_value(input jas_reg_t idx);
		logic [31:0] v;
		case ($urandom_range(0, 5))
			0: v = 32'd0;
			1: v = 32'hFFFF_FFFF;
			2: v = $urandom;
			3: v = $urandom_range(32'd1 << 12, 32'd1 << 26);
			default: begin
				case (idx)
					REG_INV_INERTIA: v = {1'b0, INV_INERTIA_RST};
					REG_DAMPING:     v = {1'b0, DAMPING_RST};
					REG_STEP_TIME:   v = STEP_TIME_RST;
					default:         v = {1'b0, MAX_STEP_RST};
				endcase
			end
		endcase
		if (idx == REG_STEP_TIME) begin
			if (v == 32'd0)
				v = 32'd1;
		end else begin
			v[31] = 1'($urandom_range(0, 1));
		end
		return v;
	endfunction

	// one register write beat; the predictor follows at once since the block is idle
	task automatic write_reg(input jas_reg_t idx, input logic [31:0] data);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		case (idx)
			REG_INV_INERTIA: gain_inv_inertia = longint'(data[30:0]);
			REG_DAMPING:     gain_damping = longint'(data[30:0]);
			REG_STEP_TIME:   gain_step_time = longint'(data);
			REG_MAX_STEP:    gain_max_step = longint'(data[30:0]);
			default:         ;
		endcase
	endtask

	task automatic end_writes();
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	// wait until every queued sample has gone in and every command has come out
	task automatic settle();
		while (sample_q.size() != 0 || cmd_expect_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// sample driver: bursts of beats with random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				cmd_expect_q.push_back(admit_step(sample_q.pop_front()));
			if (!(push && full)) begin
				if (sample_q.size() == 0) begin
					push <= 1'b0;
				end else if (gap_left > 0) begin
					gap_left--;
					push <= 1'b0;
				end else begin
					push        <= 1'b1;
					joint       <= sample_q[0].joint;
					restart     <= sample_q[0].restart;
					q_des       <= sample_q[0].q_des;
					q_act       <= sample_q[0].q_act;
					tau_act     <= sample_q[0].tau_act;
					grav_torque <= sample_q[0].grav_torque;
					bias_torque <= sample_q[0].bias_torque;
					pos_lower   <= sample_q[0].pos_lower;
					pos_upper   <= sample_q[0].pos_upper;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 16);
						case ($urandom_range(0, 3))
							0: gap_left = $urandom_range(1, 3);
							1: gap_left = $urandom_range(4, 24);
							default: gap_left = 0;
						endcase
					end
				end
			end
		end
	end

	// command monitor and pop pattern
	always @(posedge clk) begin : result_check
		command_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (cmd_expect_q.size() == 0) begin
					$display("%0t: command beat with nothing expected: joint %0d q_cmd %0d status %0d",
						$realtime, joint_out, q_cmd, status);
					mismatch_cnt++;
				end else begin
					want = cmd_expect_q.pop_front();
					if (joint_out !== want.joint || q_cmd !== want.q_cmd
						|| status !== want.status) begin
						$display("%0t: command mismatch: expected joint %0d q_cmd %0d status %0d, got joint %0d q_cmd %0d status %0d",
							$realtime, want.joint, want.q_cmd, want.status,
							joint_out, q_cmd, status);
						mismatch_cnt++;
					end
				end
			end
			// long hold-off on request, otherwise windows of different stall patterns
			if (hold_kick != hold_seen) begin
				hold_seen = hold_kick;
				rx_hold = HOLD_CYCLES;
			end
			if (rx_hold > 0) begin
				rx_hold--;
				pop <= 1'b0;
			end else begin
				if (rx_window == 0) begin
					rx_mode = $urandom_range(0, 3);
					rx_window = $urandom_range(8, 80);
				end
				rx_window--;
				case (rx_mode)
					0: pop <= 1'b1;
					1: pop <= 1'($urandom_range(0, 1));
					2: pop <= ($urandom_range(0, 4) == 0);
					default: pop <= ~pop;
				endcase
			end
		end
	end

	// watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no beat accepted for %0d cycles", $realtime, IDLE_LIMIT);
			$display("[joint_admittance_step_unit] ERROR");
			$finish;
		end
	end

	initial begin : stimulus
		int ph;
		int ch;
		for (int j = 0; j < JOINTS; j++) begin
			joint_offset[j] = 0;
			joint_velocity[j] = 0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// corners under reset settings
		@(negedge clk);
		sample_q.push_back(mk(0, 0, 0, 0, 0, 0, 0, W_MIN, W_MAX));
		sample_q.push_back(mk(7, 0, W_MAX, W_MAX, 0, 0, 0, W_MIN, W_MAX));
		sample_q.push_back(mk(1, 0, W_MIN, W_MIN, 0, 0, 0, W_MIN, W_MAX));
		// external torque clips both ways
		sample_q.push_back(mk(2, 0, 0, 0, W_MIN, W_MAX, W_MAX, W_MIN, W_MAX));
		sample_q.push_back(mk(2, 0, 0, 0, W_MAX, W_MIN, W_MIN, W_MIN, W_MAX));
		// inverted limits, above upper, below lower
		sample_q.push_back(mk(4, 0, 0, 0, 0, 0, 0, ONE, -ONE));
		sample_q.push_back(mk(5, 0, 10 * ONE, 10 * ONE, 0, 0, 0, W_MIN, 5 * ONE));
		sample_q.push_back(mk(5, 0, -10 * ONE, -10 * ONE, 0, 0, 0, -5 * ONE, W_MAX));
		// step from the measured position beyond the widest limit
		sample_q.push_back(mk(6, 0, W_MAX, W_MIN, 0, 0, 0, W_MIN, W_MAX));
		// build up state on one joint, then restart it
		repeat (3) sample_q.push_back(mk(3, 0, 0, 0, 1000 * ONE, 0, 0, W_MIN, W_MAX));
		sample_q.push_back(mk(3, 1, 0, 0, 0, 0, 0, W_MIN, W_MAX));
		settle();

		// largest inverse inertia and step time, zero damping, zero step limit
		write_reg(REG_INV_INERTIA, 32'hFFFF_FFFF);
		write_reg(REG_DAMPING, 32'h8000_0000);
		write_reg(REG_STEP_TIME, 32'hFFFF_FFFF);
		write_reg(REG_MAX_STEP, 32'h8000_0000);
		end_writes();
		@(negedge clk);
		sample_q.push_back(mk(0, 0, 0, 0, ONE, 0, 0, W_MIN, W_MAX));
		sample_q.push_back(mk(0, 1, ONE, ONE, 0, 0, 0, W_MIN, W_MAX));
		sample_q.push_back(mk(1, 1, ONE, 0, 0, 0, 0, W_MIN, W_MAX));
		settle();

		// zero integration period keeps the state frozen
		write_reg(REG_INV_INERTIA, 32'd0);
		write_reg(REG_DAMPING, 32'h7FFF_FFFF);
		write_reg(REG_STEP_TIME, 32'd0);
		end_writes();
		@(negedge clk);
		repeat (2) sample_q.push_back(mk(6, 0, 0, 0, 500 * ONE, 0, 0, W_MIN, W_MAX));
		sample_q.push_back(mk(3, 0, ONE, ONE, -500 * ONE, 0, 0, W_MIN, W_MAX));
		settle();

		// smallest nonzero gains and step time, step limit of ONE
		write_reg(REG_INV_INERTIA, 32'd1);
		write_reg(REG_DAMPING, 32'd1);
		write_reg(REG_STEP_TIME, 32'd1);
		write_reg(REG_MAX_STEP, ONE);
		end_writes();
		@(negedge clk);
		sample_q.push_back(mk(7, 0, 0, 0, W_MAX, 0, 0, W_MIN, W_MAX));
		sample_q.push_back(mk(2, 0, 2 * ONE, 0, W_MIN, 0, 0, W_MIN, W_MAX));
		settle();

		// random phases; each chunk ends with the sender waiting for all commands
		for (ph = 0; ph < RAND_PHASES; ph++) begin
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_INV_INERTIA, pick_reg_value(REG_INV_INERTIA));
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_DAMPING, pick_reg_value(REG_DAMPING));
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_STEP_TIME, pick_reg_value(REG_STEP_TIME));
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_MAX_STEP, pick_reg_value(REG_MAX_STEP));
			end_writes();
			if (ph == 1)
				hold_kick <= ~hold_kick;
			for (ch = 0; ch < CHUNKS; ch++) begin
				@(negedge clk);
				repeat (CHUNK_ITEMS) sample_q.push_back(random_sample());
				settle();
			end
		end

		settle();
		if (mismatch_cnt == 0)
			$display("[joint_admittance_step_unit] OK");
		else
			$display("[joint_admittance_step_unit] ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/jas_pkg.sv
rtl/jas_fifo.sv
rtl/jas_front.sv
rtl/jas_back.sv
rtl/joint_admittance_step_unit.sv
tb/sv/joint_admittance_step_unit_tb.sv
